FILE: rtl/i2cm_pkg.sv
package i2cm_pkg;

	localparam int RECOVERY_PULSES = 9;

	localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;
	localparam logic [15:0] STRETCH_RESET     = 16'd1000;

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_START = 3'd1,
		OP_WRITE = 3'd2,
		OP_RDACK = 3'd3,
		OP_RDNAK = 3'd4,
		OP_STOP  = 3'd5,
		OP_RECOV = 3'd6,
		OP_RSVD  = 3'd7
	} opcode_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_START_NG = 2'd1;
	localparam logic [1:0] ST_NO_ACK   = 2'd2;

	localparam logic CFG_HALF    = 1'b0;
	localparam logic CFG_STRETCH = 1'b1;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] tx_byte;
		logic       sda_in;
		logic       scl_in;
	} in_item_t;

	typedef struct packed {
		logic       scl_drive_low;
		logic       sda_drive_low;
		logic       ready_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic [1:0] status;
	} out_item_t;

endpackage

FILE: rtl/i2cm_fifo.sv
module i2cm_fifo
	import i2cm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  in_item_t  push_data,
	output logic      full,
	input  logic      pop,
	output logic      not_empty,
	output in_item_t  pop_data
);

	in_item_t   mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_data  = mem_q[rd_q];

	// store and advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/i2cm_engine.sv
module i2cm_engine
	import i2cm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	input  logic [15:0] half_ticks,
	input  logic [15:0] stretch_lim,
	output out_item_t res
);

	typedef enum logic [4:0] {
		P_IDLE, P_ST_SDA, P_ST_SCL, P_ST_WAIT, P_ST_CHK,
		P_WR_LOW, P_WR_DATA, P_WR_HIGH, P_WR_WAIT, P_WR_ACKL, P_WR_ACKL2,
		P_WR_REL, P_WR_ACKW, P_WR_CLKW, P_WR_LAST,
		P_RD_LOW, P_RD_WAIT, P_RD_SAMP, P_AK_LOW, P_AK_DATA, P_AK_WAIT, P_AK_LOW2,
		P_SP_LOW, P_SP_SDA, P_SP_WAIT, P_SP_SDAH,
		P_RC_REL, P_RC_CHK, P_RC_LOW, P_RC_HIGH, P_FIN
	} phase_t;

	phase_t      phase_q, ph;
	logic [3:0]  bit_q, bc;
	logic [7:0]  shift_q, sh, rx_q, rx;
	logic [15:0] delay_q, dl, wait_q, wt;
	logic [1:0]  stat_q, stt;
	logic        scl_q, sda_q, ack_q, scl, sda, ack, done;
	logic        run, go;
	logic        s_sda, s_scl;

	assign s_sda = item.sda_in;
	assign s_scl = item.scl_in;

	// one tick of the phase sequencer; chained phases fall through once
	always_comb begin
		ph = phase_q; bc = bit_q; sh = shift_q; rx = rx_q; dl = delay_q;
		wt = wait_q; stt = stat_q; scl = scl_q; sda = sda_q; ack = ack_q;
		done = 1'b0; run = 1'b0;
		if (phase_q == P_IDLE) begin
			wt = '0; dl = '0; run = 1'b1;
			case (opcode_t'(item.opcode))
				OP_START: ph = P_ST_SDA;
				OP_WRITE: begin sh = item.tx_byte; bc = '0; ph = P_WR_LOW; end
				OP_RDACK, OP_RDNAK: begin
					sda = 1'b0; sh = '0; bc = '0;
					ack = (item.opcode == OP_RDACK); ph = P_RD_LOW;
				end
				OP_STOP:  ph = P_SP_LOW;
				OP_RECOV: ph = P_RC_REL;
				default:  run = 1'b0;
			endcase
		end else if (delay_q != 16'd0) begin
			dl = delay_q - 16'd1;
		end else begin
			run = 1'b1;
		end
		for (int g = 0; g < 2; g++) begin
			go = run;
			run = 1'b0;
			if (go) begin
				unique case (ph)
					P_ST_SDA: begin sda = 1'b0; dl = half_ticks; ph = P_ST_SCL; end
					P_ST_SCL: begin scl = 1'b0; dl = half_ticks; ph = P_ST_WAIT; end
					P_ST_WAIT, P_WR_WAIT, P_WR_CLKW, P_RD_WAIT, P_AK_WAIT,
					P_SP_WAIT: begin
						if (scl) begin
							scl = 1'b0; dl = '0;
						end else if (!s_scl && wt < stretch_lim) begin
							wt = wt + 16'd1; dl = half_ticks;
						end else begin
							dl = half_ticks;
							case (ph)
								P_ST_WAIT: begin
									if (!s_sda) begin
										stt = ST_START_NG; ph = P_IDLE; dl = '0;
										done = 1'b1;
									end else begin
										sda = 1'b1; ph = P_ST_CHK;
									end
								end
								P_WR_WAIT: begin
									sh = {sh[6:0], 1'b0}; bc = bc + 4'd1;
									ph = (bc < 4'd8) ? P_WR_LOW : P_WR_ACKL;
								end
								P_WR_CLKW: ph = P_WR_LAST;
								P_RD_WAIT: ph = P_RD_SAMP;
								P_AK_WAIT: ph = P_AK_LOW2;
								default:   ph = P_SP_SDAH;
							endcase
						end
					end
					P_ST_CHK: begin
						if (s_sda) begin
							stt = ST_START_NG; ph = P_IDLE; dl = '0; done = 1'b1;
						end else begin
							scl = 1'b1; dl = half_ticks; ph = P_FIN;
						end
					end
					P_WR_LOW: begin scl = 1'b1; dl = half_ticks; ph = P_WR_DATA; end
					P_WR_DATA: begin sda = ~sh[7]; dl = half_ticks; ph = P_WR_HIGH; end
					P_WR_HIGH: begin scl = 1'b0; dl = half_ticks; ph = P_WR_WAIT; end
					P_WR_ACKL: begin
						scl = 1'b1; wt = '0; dl = half_ticks; ph = P_WR_ACKL2;
					end
					P_WR_ACKL2: begin scl = 1'b1; dl = half_ticks; ph = P_WR_REL; end
					P_WR_REL: begin sda = 1'b0; dl = half_ticks; ph = P_WR_ACKW; end
					P_WR_ACKW: begin
						if (s_sda) begin
							if (wt < stretch_lim) begin
								wt = wt + 16'd1; dl = half_ticks;
							end else begin
								stt = ST_NO_ACK; ph = P_IDLE; dl = '0; done = 1'b1;
							end
						end else begin
							ph = P_WR_CLKW; run = 1'b1;
						end
					end
					P_WR_LAST: begin
						scl = 1'b1; stt = ST_OK; ph = P_IDLE; dl = '0; done = 1'b1;
					end
					P_RD_LOW: begin scl = 1'b1; dl = half_ticks; ph = P_RD_WAIT; end
					P_RD_SAMP: begin
						sh = {sh[6:0], s_sda}; bc = bc + 4'd1;
						ph = (bc < 4'd8) ? P_RD_LOW : P_AK_LOW; run = 1'b1;
					end
					P_AK_LOW: begin
						rx = sh; scl = 1'b1; wt = '0; dl = half_ticks; ph = P_AK_DATA;
					end
					P_AK_DATA: begin sda = ack; dl = half_ticks; ph = P_AK_WAIT; end
					P_AK_LOW2: begin scl = 1'b1; dl = half_ticks; ph = P_FIN; end
					P_SP_LOW: begin scl = 1'b1; dl = half_ticks; ph = P_SP_SDA; end
					P_SP_SDA: begin sda = 1'b1; dl = half_ticks; ph = P_SP_WAIT; end
					P_SP_SDAH: begin sda = 1'b0; dl = half_ticks; ph = P_FIN; end
					P_RC_REL: begin sda = 1'b0; dl = half_ticks; ph = P_RC_CHK; end
					P_RC_CHK: begin
						if (s_sda) begin
							scl = 1'b0; stt = ST_OK; ph = P_IDLE; dl = '0; done = 1'b1;
						end else begin
							bc = '0; ph = P_RC_LOW; run = 1'b1;
						end
					end
					P_RC_LOW: begin scl = 1'b1; dl = half_ticks; ph = P_RC_HIGH; end
					P_RC_HIGH: begin
						scl = 1'b0; dl = half_ticks;
						if ({1'b0, bc} + 5'd1 >= 5'(RECOVERY_PULSES)) begin
							ph = P_FIN;
						end else begin
							bc = bc + 4'd1; ph = P_RC_LOW;
						end
					end
					P_FIN: begin stt = ST_OK; ph = P_IDLE; dl = '0; done = 1'b1; end
					default: ph = P_IDLE;
				endcase
			end
		end
	end

	// commit state and registered result on each step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			bit_q   <= '0;
			shift_q <= '0;
			delay_q <= '0;
			wait_q  <= '0;
			stat_q  <= ST_OK;
			scl_q   <= 1'b0;
			sda_q   <= 1'b0;
			rx_q    <= '0;
			ack_q   <= 1'b1;
			res     <= '0;
		end else if (step) begin
			phase_q <= ph;
			bit_q   <= bc;
			shift_q <= sh;
			delay_q <= dl;
			wait_q  <= wt;
			stat_q  <= stt;
			scl_q   <= scl;
			sda_q   <= sda;
			rx_q    <= rx;
			ack_q   <= ack;
			res     <= '{scl_drive_low: scl, sda_drive_low: sda,
			             ready_res: (ph == P_IDLE), done_res: done,
			             rx_byte: rx, status: stt};
		end
	end

endmodule

FILE: rtl/i2c_master_byte_engine_top.sv
// I2C master byte engine: one result per accepted tick item.
// Path from input transfer to result: two-entry queue, then the registered sequencer step.
// Throughput: one tick item per cycle while the result output is not stalled.
// Reset (arst_n low, asynchronous): engine idle, lines released, status ok,
// half period 100 and stretch timeout 1000.
module i2c_master_byte_engine_top
	import i2cm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic        full, nempty, pop, step;
	in_item_t    head;
	out_item_t   res;
	logic        res_v_q;
	logic [15:0] half_q, stretch_q;

	assign in_stall  = full;
	assign cfg_ready = 1'b1;

	i2cm_fifo u_fifo (
		.clk, .arst_n,
		.push(in_valid && !full), .push_data(in_data), .full,
		.pop, .not_empty(nempty), .pop_data(head)
	);

	// step when an item is queued and the result slot is free or frees up this cycle
	assign step = nempty && (!res_v_q || !out_stall);
	assign pop  = step;

	i2cm_engine u_eng (
		.clk, .arst_n, .step, .item(head),
		.half_ticks(half_q), .stretch_lim(stretch_q), .res
	);

	assign out_valid = res_v_q;
	assign out_data  = res;

	// hold result valid until transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q   <= 1'b0;
			half_q    <= HALF_PERIOD_RESET;
			stretch_q <= STRETCH_RESET;
		end else begin
			if (step) begin
				res_v_q <= 1'b1;
			end else if (!out_stall) begin
				res_v_q <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					CFG_HALF:    half_q    <= cfg_data;
					default:     stretch_q <= cfg_data;
				endcase
			end
		end
	end

endmodule

FILE: tb/sv/tb.sv
module tb;
	import i2cm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [4:0] {
		PH_IDLE, PH_ST_SDA, PH_ST_SCL, PH_ST_WAIT, PH_ST_CHK, PH_WR_LOW, PH_WR_DATA,
		PH_WR_HIGH, PH_WR_WAIT, PH_WR_ACKL, PH_WR_ACKL2, PH_WR_REL, PH_WR_ACKW,
		PH_WR_CLKW, PH_WR_LAST, PH_RD_LOW, PH_RD_WAIT, PH_RD_SAMP, PH_AK_LOW,
		PH_AK_DATA, PH_AK_WAIT, PH_AK_LOW2, PH_SP_LOW, PH_SP_SDA, PH_SP_WAIT,
		PH_SP_SDAH, PH_RC_REL, PH_RC_CHK, PH_RC_LOW, PH_RC_HIGH, PH_FIN
	} bus_phase_t;

	localparam int IDLE_PCT   = 32;
	localparam int WDOG_LIMIT = 5000;
	localparam int HOLD_LEN   = 400;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [15:0] cfg_data;

	i2c_master_byte_engine_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// engine mirror state
	logic [15:0] m_half, m_stretch;
	bus_phase_t  m_phase;
	logic [3:0]  m_bits;
	logic [7:0]  m_shift;
	logic [15:0] m_delay, m_wait;
	logic [1:0]  m_status;
	logic        m_scl_low, m_sda_low, m_ack, m_done, m_sda, m_scl;
	logic [7:0]  m_rx;

	in_item_t  tick_q[$];
	out_item_t line_q[$];
	int        sent_cnt, got_cnt, errors, quiet_cycles, hold_cnt;
	bit        no_idle, hold_done;

	function automatic void hold_to(bus_phase_t nxt);
		m_delay = m_half;
		m_phase = nxt;
	endfunction

	function automatic void end_cmd(logic [1:0] code);
		m_status = code;
		m_phase = PH_IDLE;
		m_delay = 0;
		m_done = 1;
	endfunction

	// true while SCL is being released or while waiting for it to be released
	function automatic bit scl_stretched();
		if (m_scl_low) begin
			m_scl_low = 0;
			m_delay = 0;
			return 1;
		end
		if (!m_scl && m_wait < m_stretch) begin
			m_wait++;
			m_delay = m_half;
			return 1;
		end
		return 0;
	endfunction

	// run one phase action; true means chain into the next at once
	function automatic bit phase_action();
		case (m_phase)
			PH_ST_SDA: begin m_sda_low = 0; hold_to(PH_ST_SCL); end
			PH_ST_SCL: begin m_scl_low = 0; hold_to(PH_ST_WAIT); end
			PH_ST_WAIT: begin
				if (scl_stretched()) return 0;
				if (!m_sda) end_cmd(ST_START_NG);
				else begin m_sda_low = 1; hold_to(PH_ST_CHK); end
			end
			PH_ST_CHK: begin
				if (m_sda) end_cmd(ST_START_NG);
				else begin m_scl_low = 1; hold_to(PH_FIN); end
			end
			PH_WR_LOW: begin m_scl_low = 1; hold_to(PH_WR_DATA); end
			PH_WR_DATA: begin m_sda_low = !m_shift[7]; hold_to(PH_WR_HIGH); end
			PH_WR_HIGH: begin m_scl_low = 0; hold_to(PH_WR_WAIT); end
			PH_WR_WAIT: begin
				if (scl_stretched()) return 0;
				m_shift = m_shift << 1;
				m_bits++;
				hold_to(m_bits < 8 ? PH_WR_LOW : PH_WR_ACKL);
			end
			PH_WR_ACKL: begin m_scl_low = 1; m_wait = 0; hold_to(PH_WR_ACKL2); end
			PH_WR_ACKL2: begin m_scl_low = 1; hold_to(PH_WR_REL); end
			PH_WR_REL: begin m_sda_low = 0; hold_to(PH_WR_ACKW); end
			PH_WR_ACKW: begin
				if (!m_sda) begin
					m_phase = PH_WR_CLKW;
					return 1;
				end
				if (m_wait < m_stretch) begin
					m_wait++;
					m_delay = m_half;
				end else end_cmd(ST_NO_ACK);
			end
			PH_WR_CLKW: begin
				if (scl_stretched()) return 0;
				hold_to(PH_WR_LAST);
			end
			PH_WR_LAST: begin m_scl_low = 1; end_cmd(ST_OK); end
			PH_RD_LOW: begin m_scl_low = 1; hold_to(PH_RD_WAIT); end
			PH_RD_WAIT: begin
				if (scl_stretched()) return 0;
				hold_to(PH_RD_SAMP);
			end
			PH_RD_SAMP: begin
				m_shift = {m_shift[6:0], m_sda};
				m_bits++;
				m_phase = m_bits < 8 ? PH_RD_LOW : PH_AK_LOW;
				return 1;
			end
			PH_AK_LOW: begin
				m_rx = m_shift; m_scl_low = 1; m_wait = 0;
				hold_to(PH_AK_DATA);
			end
			PH_AK_DATA: begin m_sda_low = m_ack; hold_to(PH_AK_WAIT); end
			PH_AK_WAIT: begin
				if (scl_stretched()) return 0;
				hold_to(PH_AK_LOW2);
			end
			PH_AK_LOW2: begin m_scl_low = 1; hold_to(PH_FIN); end
			PH_SP_LOW: begin m_scl_low = 1; hold_to(PH_SP_SDA); end
			PH_SP_SDA: begin m_sda_low = 1; hold_to(PH_SP_WAIT); end
			PH_SP_WAIT: begin
				if (scl_stretched()) return 0;
				hold_to(PH_SP_SDAH);
			end
			PH_SP_SDAH: begin m_sda_low = 0; hold_to(PH_FIN); end
			PH_RC_REL: begin m_sda_low = 0; hold_to(PH_RC_CHK); end
			PH_RC_CHK: begin
				if (m_sda) begin
					m_scl_low = 0;
					end_cmd(ST_OK);
					return 0;
				end
				m_bits = 0;
				m_phase = PH_RC_LOW;
				return 1;
			end
			PH_RC_LOW: begin m_scl_low = 1; hold_to(PH_RC_HIGH); end
			PH_RC_HIGH: begin
				m_scl_low = 0;
				if (int'(m_bits) + 1 >= RECOVERY_PULSES) hold_to(PH_FIN);
				else begin
					m_bits++;
					hold_to(PH_RC_LOW);
				end
			end
			PH_FIN: end_cmd(ST_OK);
			default: m_phase = PH_IDLE;
		endcase
		return 0;
	endfunction

	// step the mirror by one tick and queue the expected line state
	function automatic void predict_tick(in_item_t it);
		out_item_t r;
		bit go;
		go = 0;
		m_sda = it.sda_in;
		m_scl = it.scl_in;
		m_done = 0;
		if (m_phase == PH_IDLE) begin
			m_wait = 0;
			m_delay = 0;
			go = 1;
			case (opcode_t'(it.opcode))
				OP_START: m_phase = PH_ST_SDA;
				OP_WRITE: begin
					m_shift = it.tx_byte;
					m_bits = 0;
					m_phase = PH_WR_LOW;
				end
				OP_RDACK, OP_RDNAK: begin
					m_sda_low = 0;
					m_shift = 0;
					m_bits = 0;
					m_ack = (it.opcode == OP_RDACK);
					m_phase = PH_RD_LOW;
				end
				OP_STOP: m_phase = PH_SP_LOW;
				OP_RECOV: m_phase = PH_RC_REL;
				default: go = 0;
			endcase
		end else if (m_delay != 0) m_delay--;
		else go = 1;
		if (go)
			for (int g = 0; g < 8; g++)
				if (!phase_action()) break;
		r.scl_drive_low = m_scl_low;
		r.sda_drive_low = m_sda_low;
		r.ready_res = (m_phase == PH_IDLE);
		r.done_res = m_done;
		r.rx_byte = m_rx;
		r.status = m_status;
		line_q.push_back(r);
	endfunction

	function automatic in_item_t rand_tick();
		in_item_t it;
		int w;
		w = $urandom_range(99);
		if (w < 12) it.opcode = OP_NONE;
		else if (w < 14) it.opcode = OP_RSVD;
		else it.opcode = 3'($urandom_range(OP_START, OP_RECOV));
		it.tx_byte = 8'($urandom);
		it.sda_in = 1'($urandom);
		it.scl_in = ($urandom_range(99) < 85);
		return it;
	endfunction

	task automatic push_tick(opcode_t op, logic [7:0] b, logic sda, logic scl);
		in_item_t it;
		it.opcode = op;
		it.tx_byte = b;
		it.sda_in = sda;
		it.scl_in = scl;
		tick_q.push_back(it);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_HALF) m_half = val;
		else m_stretch = val;
		cfg_valid <= 0;
	endtask

	// wait until the engine has drained every queued tick and result;
	// sample between edges so that the driver and monitor have settled
	task automatic drain();
		do @(negedge clk);
		while (tick_q.size() != 0 || in_valid || line_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_phase(logic [15:0] half, logic [15:0] stretch, int n);
		write_reg(CFG_HALF, half);
		write_reg(CFG_STRETCH, stretch);
		for (int k = 0; k < n; k++) tick_q.push_back(rand_tick());
		drain();
	endtask

	// clock
	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// driver: offer queued ticks, predict on each transfer
	always @(posedge clk) begin
		bit acc;
		bit busy;
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			acc = in_valid && !in_stall;
			busy = in_valid && !acc;
			if (acc) begin
				predict_tick(in_data);
				sent_cnt++;
			end
			if (!busy) begin
				if (tick_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
					in_valid <= 1;
					in_data <= tick_q.pop_front();
				end else if (acc) begin
					in_valid <= 0;
				end
			end
		end
	end

	// monitor: stall at random, hold off once for a long stretch, check results
	always @(posedge clk) begin
		out_item_t e;
		if (!arst_n) begin
			out_stall <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got_cnt++;
				if (line_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result %h", $realtime, out_data);
				end else begin
					e = line_q.pop_front();
					if (e.scl_drive_low !== out_data.scl_drive_low ||
					    e.sda_drive_low !== out_data.sda_drive_low ||
					    e.ready_res !== out_data.ready_res ||
					    e.done_res !== out_data.done_res ||
					    e.rx_byte !== out_data.rx_byte ||
					    e.status !== out_data.status) begin
						errors++;
						$display("%0t: mismatch expected %h actual %h",
							$realtime, e, out_data);
					end
				end
			end
			if (!hold_done && got_cnt >= 300) begin
				hold_done <= 1;
				hold_cnt <= HOLD_LEN;
				out_stall <= 1;
			end else if (hold_cnt != 0) begin
				hold_cnt <= hold_cnt - 1;
				out_stall <= (hold_cnt != 1);
			end else begin
				out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// watchdog: count cycles with no transfer on the input, output or config side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// stimulus
	initial begin
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_stall = 0;
		cfg_valid = 0;
		cfg_index = CFG_HALF;
		cfg_data = 0;
		sent_cnt = 0; got_cnt = 0; errors = 0; quiet_cycles = 0; hold_cnt = 0;
		no_idle = 0; hold_done = 0;
		m_half = HALF_PERIOD_RESET; m_stretch = STRETCH_RESET;
		m_phase = PH_IDLE; m_bits = 0; m_shift = 0; m_delay = 0; m_wait = 0;
		m_status = ST_OK; m_scl_low = 0; m_sda_low = 0; m_rx = 0; m_ack = 1;
		m_done = 0; m_sda = 0; m_scl = 0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// directed: short delays, every command and failure path
		write_reg(CFG_HALF, 16'd0);
		write_reg(CFG_STRETCH, 16'd1);
		push_tick(OP_START, 8'h00, 1, 1);
		repeat (4) push_tick(OP_NONE, 8'h00, 0, 1);
		push_tick(OP_START, 8'h00, 0, 1);   // SDA low before start
		repeat (4) push_tick(OP_NONE, 8'h00, 0, 1);
		push_tick(OP_START, 8'hFF, 1, 1);   // SDA never falls
		repeat (4) push_tick(OP_NONE, 8'hFF, 1, 1);
		push_tick(OP_WRITE, 8'hFF, 1, 0);   // stretched clock, no acknowledge
		repeat (40) push_tick(OP_NONE, 8'h00, 1, 0);
		push_tick(OP_WRITE, 8'h00, 0, 1);
		repeat (40) push_tick(OP_NONE, 8'h00, 0, 1);
		push_tick(OP_RDACK, 8'h00, 1, 1);
		repeat (30) push_tick(OP_NONE, 8'h00, 1, 1);
		push_tick(OP_RDNAK, 8'h00, 0, 1);
		repeat (30) push_tick(OP_NONE, 8'h00, 0, 1);
		push_tick(OP_STOP, 8'h00, 1, 1);
		push_tick(OP_RSVD, 8'h00, 1, 1);
		repeat (6) push_tick(OP_NONE, 8'h00, 1, 1);
		push_tick(OP_RECOV, 8'h00, 1, 1);   // SDA already high
		push_tick(OP_NONE, 8'h00, 1, 1);
		push_tick(OP_RECOV, 8'h00, 0, 1);   // stuck SDA, nine pulses
		repeat (30) push_tick(OP_NONE, 8'h00, 0, 1);
		drain();

		// random phases across register settings
		run_phase(16'd0, 16'd0, 200);
		run_phase(16'd1, 16'd3, 250);
		no_idle = 1;
		run_phase(16'd0, 16'd2, 200);
		no_idle = 0;
		run_phase(16'hFFFF, 16'hFFFF, 40);
		run_phase(16'd2, 16'hFFFF, 200);
		run_phase(16'd0, 16'd5, 250);

		repeat (10) @(posedge clk);
		if (errors == 0 && line_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

FILE: sim.f
rtl/i2cm_pkg.sv
rtl/i2cm_fifo.sv
rtl/i2cm_engine.sv
rtl/i2c_master_byte_engine_top.sv
tb/sv/tb.sv
